@@ design/wss_pkg.sv @@
// Shared constants, types and controller encodings for the windowed sample
// statistics block. Used by the interfaces, the controller, the datapath
// and the top level.
package wss_pkg;

   // Store geometry and field widths
   localparam int MAX_WINDOW  = 64;
   localparam int SAMPLE_BITS = 10;
   localparam int ADDR_W      = $clog2(MAX_WINDOW);
   localparam int COUNT_W     = $clog2(MAX_WINDOW + 1);
   localparam int PERIOD_W    = 16;
   localparam int TICKS_W     = 8;
   localparam int WINDOW_W    = 7;
   localparam int MEAN_W      = 14;
   localparam int FRAC_BITS   = 4;

   // Accumulator and divider widths
   localparam int SUM_W     = SAMPLE_BITS + COUNT_W;
   localparam int DIV_W     = SUM_W + FRAC_BITS;
   localparam int DIV_CNT_W = $clog2(DIV_W);

   // Configuration port
   localparam int CSR_IDX_W  = 8;
   localparam int CSR_DATA_W = 16;
   localparam logic [CSR_IDX_W-1:0] CSR_PERIOD_MS  = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_WINDOW_LEN = CSR_IDX_W'(1);

   localparam logic [WINDOW_W-1:0] WINDOW_RESET = WINDOW_W'(16);

   // Controller states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECIDE,
      ST_WALK,
      ST_DRAIN,
      ST_DIV_INIT,
      ST_DIV,
      ST_STATS,
      ST_RESULT
   } wss_state_type;

   // Commands from controller to datapath
   typedef struct packed {
      logic accept;
      logic commit;
      logic walk_read;
      logic div_init;
      logic div_step;
      logic stats_load;
      logic rsp_load;
   } wss_cmd_type;

   // Status from datapath to controller
   typedef struct packed {
      logic take;
      logic walk_last;
      logic div_last;
      logic out_busy;
   } wss_status_type;

endpackage

@@ design/wss_if.sv @@
// Valid/ready channel interfaces for poll items, result items and
// configuration writes. Depends on wss_pkg for the field widths.
interface wss_req_if import wss_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic [SAMPLE_BITS-1:0] adc_value;
   logic [TICKS_W-1:0]     ticks_passed;

   modport source (output valid, output adc_value, output ticks_passed, input ready);
   modport sink   (input valid, input adc_value, input ticks_passed, output ready);
endinterface

interface wss_rsp_if import wss_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic                   sampled;
   logic [SAMPLE_BITS-1:0] newest;
   logic [SAMPLE_BITS-1:0] window_min;
   logic [SAMPLE_BITS-1:0] window_max;
   logic [MEAN_W-1:0]      mean_x16;
   logic [COUNT_W-1:0]     fill_count;

   modport source (output valid, output sampled, output newest, output window_min,
                   output window_max, output mean_x16, output fill_count, input ready);
   modport sink   (input valid, input sampled, input newest, input window_min,
                   input window_max, input mean_x16, input fill_count, output ready);
endinterface

interface wss_csr_if import wss_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

@@ design/wss_controller.sv @@
// Sequencing state machine: accept a poll; if it stores a sample, walk the
// ring and run the serial divide; hand the item to the output register.
// Depends on wss_pkg.
module wss_controller import wss_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_ready,
   input  wss_status_type status,
   output wss_cmd_type    cmd
);

   wss_state_type state_ff;
   wss_state_type state_in;

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and commands
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            if (status.take) begin
               cmd.commit = 1'b1;
               state_in   = ST_WALK;
            end else begin
               state_in = ST_RESULT;
            end
         end
         ST_WALK: begin
            cmd.walk_read = 1'b1;
            if (status.walk_last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = ST_DIV_INIT;
         end
         ST_DIV_INIT: begin
            cmd.div_init = 1'b1;
            state_in     = ST_DIV;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (status.div_last) begin
               state_in = ST_STATS;
            end
         end
         ST_STATS: begin
            cmd.stats_load = 1'b1;
            state_in       = ST_RESULT;
         end
         ST_RESULT: begin
            if (!status.out_busy) begin
               cmd.rsp_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

@@ design/wss_datapath.sv @@
// Datapath: configuration registers, elapsed-time counter, sample ring,
// min/max/sum walk, restoring divider and the output register.
// Depends on wss_pkg; driven by wss_controller commands.
module wss_datapath import wss_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  wss_cmd_type            cmd,
   output wss_status_type         status,
   // configuration writes
   input  logic                   csr_write,
   input  logic [CSR_IDX_W-1:0]   csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data,
   // poll payload
   input  logic [SAMPLE_BITS-1:0] req_adc_value,
   input  logic [TICKS_W-1:0]     req_ticks_passed,
   // result channel
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic                   rsp_sampled,
   output logic [SAMPLE_BITS-1:0] rsp_newest,
   output logic [SAMPLE_BITS-1:0] rsp_window_min,
   output logic [SAMPLE_BITS-1:0] rsp_window_max,
   output logic [MEAN_W-1:0]      rsp_mean_x16,
   output logic [COUNT_W-1:0]     rsp_fill_count
);

   // Configuration and window state
   logic [PERIOD_W-1:0]    period_ff;
   logic [WINDOW_W-1:0]    window_ff;
   logic [PERIOD_W-1:0]    since_ff;
   logic [ADDR_W-1:0]      pos_ff;
   logic [COUNT_W-1:0]     count_ff;
   logic [SAMPLE_BITS-1:0] newest_ff;
   logic [SAMPLE_BITS-1:0] held_min_ff;
   logic [SAMPLE_BITS-1:0] held_max_ff;
   logic [MEAN_W-1:0]      held_mean_ff;
   logic                   take_ff;
   logic [SAMPLE_BITS-1:0] sample_ff;

   // Walk and divide
   logic [SAMPLE_BITS-1:0] ring_mem [MAX_WINDOW];
   logic [SAMPLE_BITS-1:0] rd_data_ff;
   logic [ADDR_W-1:0]      idx_ff;
   logic                   acc_en_ff;
   logic [SUM_W-1:0]       sum_ff;
   logic [SAMPLE_BITS-1:0] min_ff;
   logic [SAMPLE_BITS-1:0] max_ff;
   logic [COUNT_W-1:0]     rem_ff;
   logic [DIV_W-1:0]       quo_ff;
   logic [DIV_CNT_W-1:0]   div_cnt_ff;
   logic                   out_valid_ff;

   logic [COUNT_W-1:0]  len;
   logic [PERIOD_W:0]   since_sum;
   logic [PERIOD_W-1:0] since_next;
   logic                take_now;
   logic                window_write;
   logic [COUNT_W:0]    pos_inc;
   logic [COUNT_W:0]    div_shift;
   logic                div_ge;

   // Clamp window length to 1..MAX_WINDOW
   always_comb begin
      priority if (window_ff == '0) begin
         len = COUNT_W'(1);
      end else if (window_ff > WINDOW_W'(MAX_WINDOW)) begin
         len = COUNT_W'(MAX_WINDOW);
      end else begin
         len = COUNT_W'(window_ff);
      end
   end

   // Saturating elapsed time and the store decision
   assign since_sum  = {1'b0, since_ff} + (PERIOD_W + 1)'(req_ticks_passed);
   assign since_next = since_sum[PERIOD_W] ? '1 : since_sum[PERIOD_W-1:0];
   assign take_now   = (period_ff == '0) || (since_next >= period_ff) || (count_ff == '0);

   assign window_write = csr_write && (csr_index == CSR_WINDOW_LEN);
   assign pos_inc      = (COUNT_W + 1)'(pos_ff) + (COUNT_W + 1)'(1);

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         period_ff <= '0;
         window_ff <= WINDOW_RESET;
      end else if (csr_write) begin
         if (csr_index == CSR_PERIOD_MS) begin
            period_ff <= csr_data[PERIOD_W-1:0];
         end
         if (window_write) begin
            window_ff <= csr_data[WINDOW_W-1:0];
         end
      end
   end

   // Window state: restart on reset or window length write
   always_ff @(posedge clock) begin
      if (reset || window_write) begin
         since_ff     <= '0;
         pos_ff       <= '0;
         count_ff     <= '0;
         newest_ff    <= '0;
         held_min_ff  <= '0;
         held_max_ff  <= '0;
         held_mean_ff <= '0;
      end else begin
         if (cmd.accept) begin
            since_ff <= since_next;
         end
         if (cmd.commit) begin
            since_ff  <= '0;
            newest_ff <= sample_ff;
            pos_ff    <= (pos_inc >= (COUNT_W + 1)'(len)) ? '0 : pos_inc[ADDR_W-1:0];
            count_ff  <= (count_ff >= len) ? len : count_ff + COUNT_W'(1);
         end
         if (cmd.stats_load) begin
            held_min_ff  <= min_ff;
            held_max_ff  <= max_ff;
            held_mean_ff <= quo_ff[MEAN_W-1:0];
         end
      end
   end

   // Latch the poll payload and its decision
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         sample_ff <= req_adc_value;
         take_ff   <= take_now;
      end
   end

   // Sample ring: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         ring_mem[pos_ff] <= sample_ff;
      end
      rd_data_ff <= ring_mem[idx_ff];
   end

   // Read index and read-data valid
   always_ff @(posedge clock) begin
      if (reset) begin
         acc_en_ff <= 1'b0;
      end else begin
         acc_en_ff <= cmd.walk_read;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         idx_ff <= '0;
      end else if (cmd.walk_read) begin
         idx_ff <= idx_ff + ADDR_W'(1);
      end
   end

   // Accumulate sum, minimum and maximum over the filled entries
   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         sum_ff <= '0;
         min_ff <= '1;
         max_ff <= '0;
      end else if (acc_en_ff) begin
         sum_ff <= sum_ff + SUM_W'(rd_data_ff);
         if (rd_data_ff < min_ff) begin
            min_ff <= rd_data_ff;
         end
         if (rd_data_ff > max_ff) begin
            max_ff <= rd_data_ff;
         end
      end
   end

   // Restoring divide of 16*sum by the fill count, one quotient bit a cycle
   assign div_shift = {rem_ff, quo_ff[DIV_W-1]};
   assign div_ge    = div_shift >= (COUNT_W + 1)'(count_ff);

   always_ff @(posedge clock) begin
      if (cmd.div_init) begin
         quo_ff     <= {sum_ff, {FRAC_BITS{1'b0}}};
         rem_ff     <= '0;
         div_cnt_ff <= '0;
      end else if (cmd.div_step) begin
         rem_ff     <= div_ge ? COUNT_W'(div_shift - (COUNT_W + 1)'(count_ff))
                              : COUNT_W'(div_shift);
         quo_ff     <= {quo_ff[DIV_W-2:0], div_ge};
         div_cnt_ff <= div_cnt_ff + DIV_CNT_W'(1);
      end
   end

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (cmd.rsp_load) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         rsp_sampled    <= take_ff;
         rsp_newest     <= newest_ff;
         rsp_window_min <= held_min_ff;
         rsp_window_max <= held_max_ff;
         rsp_mean_x16   <= held_mean_ff;
         rsp_fill_count <= count_ff;
      end
   end

   assign rsp_valid = out_valid_ff;

   // Status to the controller
   assign status.take      = take_ff;
   assign status.walk_last = (idx_ff == ADDR_W'(count_ff - COUNT_W'(1)));
   assign status.div_last  = (div_cnt_ff == DIV_CNT_W'(DIV_W - 1));
   assign status.out_busy  = out_valid_ff && !rsp_ready;

endmodule

@@ design/windowed_sample_statistics.sv @@
// Top level of the windowed sample statistics block: controller, datapath
// and channel hookup. Depends on wss_pkg, wss_if, wss_controller, wss_datapath.
//
//   channel    direction  handshake     payload
//   req_chan   in         valid/ready   adc_value, ticks_passed
//   rsp_chan   out        valid/ready   sampled, newest, window_min, window_max,
//                                       mean_x16, fill_count
//   csr_chan   in         valid/ready   index, data (ready always high)
//
// A poll that stores no sample passes through the decide and result states to
// the output register. A poll that stores a sample first takes one ring read
// per filled entry, then a 21-step restoring divide.
// One item is in work at a time; the next poll is taken once the result sits
// in the output register, so a stalled output holds back at most one item.
// Synchronous reset clears control state; ring entries stay undefined, as
// only entries written since the last restart are ever read.
module windowed_sample_statistics import wss_pkg::*; (
   input logic       clock,
   input logic       reset,
   wss_req_if.sink   req_chan,
   wss_rsp_if.source rsp_chan,
   wss_csr_if.sink   csr_chan
);

   wss_cmd_type    cmd;
   wss_status_type status;

   assign csr_chan.ready = 1'b1;

   // Sequencer
   wss_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .status    (status),
      .cmd       (cmd)
   );

   // Storage and arithmetic
   wss_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .csr_write        (csr_chan.valid),
      .csr_index        (csr_chan.index),
      .csr_data         (csr_chan.data),
      .req_adc_value    (req_chan.adc_value),
      .req_ticks_passed (req_chan.ticks_passed),
      .rsp_valid        (rsp_chan.valid),
      .rsp_ready        (rsp_chan.ready),
      .rsp_sampled      (rsp_chan.sampled),
      .rsp_newest       (rsp_chan.newest),
      .rsp_window_min   (rsp_chan.window_min),
      .rsp_window_max   (rsp_chan.window_max),
      .rsp_mean_x16     (rsp_chan.mean_x16),
      .rsp_fill_count   (rsp_chan.fill_count)
   );

   // The block does not take another poll in the cycle after it takes one
   assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready) |=> !req_chan.ready)
      else $error("poll taken while previous item still in work");

   // Every result follows a stored sample, so the window is never empty
   assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> (rsp_chan.fill_count != '0)
                      && (rsp_chan.window_min <= rsp_chan.window_max))
      else $error("result with empty window or min above max");

   // Newest sample and mean lie within the window extremes
   assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> (rsp_chan.newest >= rsp_chan.window_min)
                      && (rsp_chan.newest <= rsp_chan.window_max)
                      && (rsp_chan.mean_x16 >= MEAN_W'({rsp_chan.window_min, 4'b0000}))
                      && (rsp_chan.mean_x16 <= MEAN_W'({rsp_chan.window_max, 4'b0000})))
      else $error("result statistics inconsistent");

endmodule
